/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define R2Y_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

`define R2Y_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) !(cond)) \
    else $error(msg);

`else

`define R2Y_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg)

`define R2Y_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg)

`endif

`endif

/* rtl/r2y_pkg.sv */
// package for the rgb565 pair to yuyv converter: word types, coefficients,
// channel expansion helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package r2y_pkg;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = 16;

  localparam logic [SUM_W-1:0] Y_COEF_R   = 16'd66;
  localparam logic [SUM_W-1:0] Y_COEF_G   = 16'd129;
  localparam logic [SUM_W-1:0] Y_COEF_B   = 16'd25;
  localparam logic [SUM_W-1:0] CB_COEF_R  = 16'd38;
  localparam logic [SUM_W-1:0] CB_COEF_G  = 16'd74;
  localparam logic [SUM_W-1:0] CB_COEF_B  = 16'd112;
  localparam logic [SUM_W-1:0] CR_COEF_R  = 16'd112;
  localparam logic [SUM_W-1:0] CR_COEF_G  = 16'd94;
  localparam logic [SUM_W-1:0] CR_COEF_B  = 16'd18;
  localparam logic [CHAN_W-1:0] Y_OFFSET  = 8'd16;
  localparam logic [SUM_W-1:0] C_BIAS     = 16'd32768;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_second;
    logic [PIX_W-1:0] pixel_first;
  } pix_pair_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chroma_red;
    logic [CHAN_W-1:0] luma_second;
    logic [CHAN_W-1:0] chroma_blue;
    logic [CHAN_W-1:0] luma_first;
  } yuyv_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [SUM_W-1:0]  luma_sum;
  } lane_res_t;

  function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] c);
    expand5 = {c, c[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] c);
    expand6 = {c, c[5:4]};
  endfunction

endpackage

`default_nettype wire

/* rtl/r2y_lane.sv */
// one pixel lane: expands rgb565 to 8-bit channels and forms the luma sum
// depends on r2y_pkg
`timescale 1ns / 1ps
`default_nettype none

module r2y_lane import r2y_pkg::*; (
  input  wire logic              clk,
  input  wire logic [PIX_W-1:0]  pixel,
  output lane_res_t              res_r
);

  lane_res_t res_nxt;

  always_comb begin
    res_nxt.red      = expand5(pixel[15:11]);
    res_nxt.green    = expand6(pixel[10:5]);
    res_nxt.blue     = expand5(pixel[4:0]);
    res_nxt.luma_sum = SUM_W'(res_nxt.red)   * Y_COEF_R
                     + SUM_W'(res_nxt.green) * Y_COEF_G
                     + SUM_W'(res_nxt.blue)  * Y_COEF_B;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

/* rtl/r2y_merge.sv */
// merge stage: averages the two lanes, forms shared chroma, packs the word
// depends on r2y_pkg
`timescale 1ns / 1ps
`default_nettype none

module r2y_merge import r2y_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       valid,
  input  wire lane_res_t  lane0,
  input  wire lane_res_t  lane1,
  output logic            valid_r,
  output yuyv_t           word_r
);

  logic [CHAN_W:0]   sum_r_ch, sum_g_ch, sum_b_ch;
  logic [CHAN_W-1:0] avg_r, avg_g, avg_b;
  logic [SUM_W-1:0]  cb_sum, cr_sum;
  yuyv_t             word_nxt;

  always_comb begin
    sum_r_ch = {1'b0, lane0.red}   + {1'b0, lane1.red};
    sum_g_ch = {1'b0, lane0.green} + {1'b0, lane1.green};
    sum_b_ch = {1'b0, lane0.blue}  + {1'b0, lane1.blue};
    avg_r    = sum_r_ch[CHAN_W:1];
    avg_g    = sum_g_ch[CHAN_W:1];
    avg_b    = sum_b_ch[CHAN_W:1];
    // biased sums stay in 0..65535, so wrapping arithmetic is exact
    cb_sum = C_BIAS + SUM_W'(avg_b) * CB_COEF_B
           - SUM_W'(avg_r) * CB_COEF_R - SUM_W'(avg_g) * CB_COEF_G;
    cr_sum = C_BIAS + SUM_W'(avg_r) * CR_COEF_R
           - SUM_W'(avg_g) * CR_COEF_G - SUM_W'(avg_b) * CR_COEF_B;
    word_nxt.luma_first  = lane0.luma_sum[15:8] + Y_OFFSET;
    word_nxt.luma_second = lane1.luma_sum[15:8] + Y_OFFSET;
    word_nxt.chroma_blue = cb_sum[15:8];
    word_nxt.chroma_red  = cr_sum[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

/* rtl/rgb565_pair_to_yuyv_bt601_unit.sv */
// top level: rgb565 pixel pair to one yuyv word, bt.601 studio range
// depends on r2y_pkg, r2y_lane, r2y_merge and assert_macros.svh
//
// A pair is taken on every clock where start is high; busy is always low.
// Each pair gives one word on out_word, marked by a one-cycle out_valid
// strobe, after passing the registers of the two pixel lanes (channel
// expansion and luma sums), then the merge stage (averaging and chroma).
// The receiver cannot stall; the word is present for that cycle only.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rgb565_pair_to_yuyv_bt601_unit import r2y_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire pix_pair_t  in_pair,
  output logic            out_valid,
  output yuyv_t           out_word
);

  logic      take;
  logic      lane_valid_r;
  lane_res_t lane0_res, lane1_res;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_valid_r <= 1'b0;
    end else begin
      lane_valid_r <= take;
    end
  end

  r2y_lane u_lane0 (
    .clk   (clk),
    .pixel (in_pair.pixel_first),
    .res_r (lane0_res)
  );

  r2y_lane u_lane1 (
    .clk   (clk),
    .pixel (in_pair.pixel_second),
    .res_r (lane1_res)
  );

  r2y_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (lane_valid_r),
    .lane0   (lane0_res),
    .lane1   (lane1_res),
    .valid_r (out_valid),
    .word_r  (out_word)
  );

  `R2Y_ASSERT_IMPLY(a_out_follows_take, clk, rst_n, out_valid && $past(rst_n, 2), $past(take, 2), "word without a pair")
  `R2Y_ASSERT_IMPLY(a_take_gives_lane, clk, rst_n, $past(take) && $past(rst_n), lane_valid_r, "pair dropped in lanes")
  `R2Y_ASSERT_IMPLY(a_luma_range, clk, rst_n, out_valid, out_word.luma_first >= 8'd16 && out_word.luma_first <= 8'd235 && out_word.luma_second >= 8'd16 && out_word.luma_second <= 8'd235, "luma out of range")

endmodule

`default_nettype wire

/* tb/tb.sv */
// testbench for rgb565_pair_to_yuyv_bt601_unit: drives pixel pairs, predicts
// each yuyv word and checks it field by field at the output strobe
// depends on r2y_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb;
  import r2y_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  pix_pair_t in_pair;
  logic      out_valid;
  yuyv_t     out_word;

  yuyv_t     pending_words[$];
  int        mismatch_count;
  int        max_gap;

  rgb565_pair_to_yuyv_bt601_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pair   (in_pair),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int widen5(logic [4:0] c);
    return (int'(c) << 3) | (int'(c) >> 2);
  endfunction

  function automatic int widen6(logic [5:0] c);
    return (int'(c) << 2) | (int'(c) >> 4);
  endfunction

  function automatic logic [7:0] luma_of_rgb(int r, int g, int b);
    int s;
    s = ((66 * r + 129 * g + 25 * b) >> 8) + 16;
    return s[7:0];
  endfunction

  function automatic yuyv_t yuyv_of_pair(pix_pair_t p);
    int    r0, g0, b0, r1, g1, b1;
    int    ra, ga, ba, cb, cr;
    yuyv_t w;
    r0 = widen5(p.pixel_first[15:11]);
    g0 = widen6(p.pixel_first[10:5]);
    b0 = widen5(p.pixel_first[4:0]);
    r1 = widen5(p.pixel_second[15:11]);
    g1 = widen6(p.pixel_second[10:5]);
    b1 = widen5(p.pixel_second[4:0]);
    ra = (r0 + r1) >> 1;
    ga = (g0 + g1) >> 1;
    ba = (b0 + b1) >> 1;
    // biased sums stay positive, so the shift floors
    cb = (32768 + 112 * ba - 38 * ra - 74 * ga) >> 8;
    cr = (32768 + 112 * ra - 94 * ga - 18 * ba) >> 8;
    w.luma_first  = luma_of_rgb(r0, g0, b0);
    w.chroma_blue = cb[7:0];
    w.luma_second = luma_of_rgb(r1, g1, b1);
    w.chroma_red  = cr[7:0];
    return w;
  endfunction

  // called just after a rising edge, returns at the edge that takes the pair
  task automatic send_pair(input logic [15:0] first, input logic [15:0] second);
    int        gap;
    pix_pair_t p;
    p.pixel_first  = first;
    p.pixel_second = second;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_pair <= p;
    @(negedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
      @(negedge clk);
    end
    pending_words.push_back(yuyv_of_pair(p));
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    yuyv_t w;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("word with no expectation: %h", out_word);
        mismatch_count++;
      end else begin
        w = pending_words.pop_front();
        check_field("luma_first", w.luma_first, out_word.luma_first);
        check_field("chroma_blue", w.chroma_blue, out_word.chroma_blue);
        check_field("luma_second", w.luma_second, out_word.luma_second);
        check_field("chroma_red", w.chroma_red, out_word.chroma_red);
      end
    end
  end

  task automatic test_directed();
    max_gap = 5;
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hF800, 16'hF800);
    send_pair(16'h07E0, 16'h07E0);
    send_pair(16'h001F, 16'h001F);
    send_pair(16'hF800, 16'h07E0);
    send_pair(16'h07E0, 16'h001F);
    send_pair(16'h001F, 16'hF800);
    send_pair(16'hF81F, 16'hF81F);
    send_pair(16'h07FF, 16'h07FF);
    send_pair(16'hFFE0, 16'hFFE0);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
    // some of these give odd channel sums, so the pair average floors
    send_pair(16'h0821, 16'h0000);
    send_pair(16'h8410, 16'h7BEF);
    send_pair(16'h0001, 16'h0800);
    send_pair(16'h0020, 16'hFFDF);
  endtask

  task automatic test_random_bursts(input int count);
    for (int i = 0; i < count; i++) begin
      // every 40 pairs, pick at random a stretch with or without sender gaps
      if (i % 40 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 5;
      send_pair(16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_smooth_pairs(input int count);
    logic [15:0] base;
    logic [15:0] near;
    max_gap = 5;
    for (int i = 0; i < count; i++) begin
      base = 16'($urandom);
      near = base ^ 16'($urandom_range(0, 7) << ($urandom_range(0, 2) * 5));
      send_pair(base, near);
    end
  endtask

  task automatic test_drain_pause();
    max_gap = 0;
    repeat (20) send_pair(16'($urandom), 16'($urandom));
    wait_drained();
    repeat (20) send_pair(16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_pair        = '0;
    mismatch_count = 0;
    max_gap        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_bursts(450);
    test_drain_pause();
    test_smooth_pairs(150);
    test_random_bursts(300);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
